// ===== hdl/pcb_pkg.sv =====
// Shared types, codes and constants of the point cloud max-height binner.
package pcb_pkg;

  localparam int unsigned GRID_CELLS_DEFAULT = 65536;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned SIZE_W    = 20;
  localparam int unsigned WIDTH_W   = 17;
  localparam int unsigned MASK_W    = 64;
  localparam int unsigned CLASS_W   = 8;
  localparam int unsigned RIDX_W    = 16;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned PROD_W    = COORD_W + WIDTH_W;
  localparam int unsigned SUM_W     = PROD_W + 1;
  localparam int unsigned PADDR_W   = 6;
  localparam int unsigned PDATA_W   = 64;
  localparam int unsigned REG_SEL_W = 3;

  // Divider: two restoring steps per clock
  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned DIV_CYCLES = COORD_W / DIV_STEPS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES);

  localparam logic [STATUS_W-1:0] STATUS_BINNED   = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_REJECTED = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_OUTSIDE  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_BEYOND   = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_READ     = 3'd4;

  localparam logic CMD_BIN  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [REG_SEL_W-1:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [REG_SEL_W-1:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [REG_SEL_W-1:0] REG_LIMIT_X      = 3'd2;
  localparam logic [REG_SEL_W-1:0] REG_LIMIT_Y      = 3'd3;
  localparam logic [REG_SEL_W-1:0] REG_CELL_SIZE    = 3'd4;
  localparam logic [REG_SEL_W-1:0] REG_GRID_WIDTH   = 3'd5;
  localparam logic [REG_SEL_W-1:0] REG_INCLUDE_MASK = 3'd6;
  localparam logic [REG_SEL_W-1:0] REG_EXCLUDE_MASK = 3'd7;

  typedef struct packed {
    logic                      command;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [CLASS_W-1:0]        point_class;
    logic [RIDX_W-1:0]         read_index;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [RIDX_W-1:0]         cell_index;
    logic signed [COORD_W-1:0] cell_height;
    logic                      cell_has_data;
  } rsp_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] limit_x;
    logic signed [COORD_W-1:0] limit_y;
    logic [SIZE_W-1:0]         cell_size;
    logic [WIDTH_W-1:0]        grid_width;
    logic [MASK_W-1:0]         include_mask;
    logic [MASK_W-1:0]         exclude_mask;
  } cfg_t;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_CHECK = 10'b0000000100,
    S_DIVX  = 10'b0000001000,
    S_DIVY  = 10'b0000010000,
    S_MUL   = 10'b0000100000,
    S_ADD   = 10'b0001000000,
    S_IDX   = 10'b0010000000,
    S_LOOK  = 10'b0100000000,
    S_UPD   = 10'b1000000000
  } state_t;

endpackage

// ===== hdl/pcb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pcb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = pcb_pkg::GRID_CELLS_DEFAULT,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/pcb_div.sv =====
// Shared restoring divider: 32-bit dividend by 20-bit divisor, two quotient bits per clock.
module pcb_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pcb_pkg::COORD_W-1:0] dividend,
  input  logic [pcb_pkg::SIZE_W-1:0]  divisor,
  output logic                       done,
  output logic [pcb_pkg::COORD_W-1:0] quotient
);
  import pcb_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [SIZE_W-1:0]    den;
  logic [SIZE_W-1:0]    rem;
  logic [COORD_W-1:0]   dq;
  logic [SIZE_W-1:0]    rem_next;
  logic [COORD_W-1:0]   dq_next;

  always_comb begin
    logic [SIZE_W:0]    trial;
    logic [SIZE_W-1:0]  r;
    logic [COORD_W-1:0] q;
    r = rem;
    q = dq;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {r, q[COORD_W-1]};
      q     = {q[COORD_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        trial = trial - {1'b0, den};
        q[0]  = 1'b1;
      end
      r = trial[SIZE_W-1:0];
    end
    rem_next = r;
    dq_next  = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den <= divisor;
      rem <= '0;
      dq  <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      dq  <= dq_next;
    end
  end

  assign quotient = dq;

endmodule

// ===== hdl/pcb_regs.sv =====
// APB-style configuration register file.
module pcb_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pcb_pkg::PADDR_W-1:0] paddr,
  input  logic [pcb_pkg::PDATA_W-1:0] pwdata,
  output logic [pcb_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output pcb_pkg::cfg_t               cfg
);
  import pcb_pkg::*;

  logic [REG_SEL_W-1:0] sel;

  assign sel    = paddr[PADDR_W-1:PADDR_W-REG_SEL_W];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x     <= '0;
      cfg.origin_y     <= '0;
      cfg.limit_x      <= 32'sd255;
      cfg.limit_y      <= 32'sd255;
      cfg.cell_size    <= SIZE_W'(1);
      cfg.grid_width   <= WIDTH_W'(256);
      cfg.include_mask <= '1;
      cfg.exclude_mask <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (sel)
        REG_ORIGIN_X:     cfg.origin_x     <= pwdata[COORD_W-1:0];
        REG_ORIGIN_Y:     cfg.origin_y     <= pwdata[COORD_W-1:0];
        REG_LIMIT_X:      cfg.limit_x      <= pwdata[COORD_W-1:0];
        REG_LIMIT_Y:      cfg.limit_y      <= pwdata[COORD_W-1:0];
        REG_CELL_SIZE:    cfg.cell_size    <= pwdata[SIZE_W-1:0];
        REG_GRID_WIDTH:   cfg.grid_width   <= pwdata[WIDTH_W-1:0];
        REG_INCLUDE_MASK: cfg.include_mask <= pwdata;
        REG_EXCLUDE_MASK: cfg.exclude_mask <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_ORIGIN_X:     prdata = PDATA_W'(unsigned'(cfg.origin_x));
      REG_ORIGIN_Y:     prdata = PDATA_W'(unsigned'(cfg.origin_y));
      REG_LIMIT_X:      prdata = PDATA_W'(unsigned'(cfg.limit_x));
      REG_LIMIT_Y:      prdata = PDATA_W'(unsigned'(cfg.limit_y));
      REG_CELL_SIZE:    prdata = PDATA_W'(cfg.cell_size);
      REG_GRID_WIDTH:   prdata = PDATA_W'(cfg.grid_width);
      REG_INCLUDE_MASK: prdata = cfg.include_mask;
      REG_EXCLUDE_MASK: prdata = cfg.exclude_mask;
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== hdl/point_cloud_max_height_binner_top.sv =====
// Top level of the point cloud max-height binner: sequencer, index math and cell stores.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  req     | in        | req_valid/req_ready | req_t: command, point, class, index
//  rsp     | out       | rsp_valid/rsp_ready | rsp_t: status, cell index/height/mark
//  apb     | in        | psel/penable/pready | 8 registers at 8*i, 64-bit data
//
// A bin item passes a check state, then two divisions in series on the shared divider
// (x, then y, each in 16 two-bit steps), then multiply, add, index check, lookup,
// update and output load. A read item goes from the check to the index check, lookup
// and update; a rejected or out-of-range point or a read beyond the store ends at the
// check, and a point whose index lands beyond the store ends at the index check.
// After reset a clearing pass zeroes the has-data store, one entry per cycle, over all
// GRID_CELLS entries; req_ready stays low meanwhile while register writes still land.
// One item is in work at a time; the next transfer can land only once the result has
// moved into the output register, so a result stalled there holds off the input.
module point_cloud_max_height_binner_top #(
  parameter int unsigned GRID_CELLS = pcb_pkg::GRID_CELLS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  pcb_pkg::req_t               req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output pcb_pkg::rsp_t               rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pcb_pkg::PADDR_W-1:0] paddr,
  input  logic [pcb_pkg::PDATA_W-1:0] pwdata,
  output logic [pcb_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import pcb_pkg::*;

  localparam int unsigned IDXW = $clog2(GRID_CELLS);

  cfg_t   cfg;
  state_t state;
  req_t   item;
  rsp_t   res;
  logic   res_valid;

  logic [COORD_W-1:0] rx;
  logic [COORD_W-1:0] ry;
  logic [PROD_W-1:0]  prod;
  logic [SUM_W-1:0]   idx;
  logic [IDXW-1:0]    clr_cnt;

  logic               div_start;
  logic               div_done;
  logic [COORD_W-1:0] div_num;
  logic [SIZE_W-1:0]  div_den;
  logic [COORD_W-1:0] div_quot;
  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;

  logic               class_ok;
  logic               range_ok;
  logic               h_we;
  logic signed [COORD_W-1:0] h_rd;
  logic signed [COORD_W-1:0] h_new;
  logic               m_we;
  logic [IDXW-1:0]    m_waddr;
  logic [0:0]         m_wdata;
  logic [0:0]         m_rd;
  logic               out_free;

  pcb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign dx      = unsigned'(item.point_x) - unsigned'(cfg.origin_x);
  assign dy      = unsigned'(item.point_y) - unsigned'(cfg.origin_y);
  assign div_den = (cfg.cell_size == '0) ? SIZE_W'(1) : cfg.cell_size;
  assign div_num = (state == S_CHECK) ? dx : dy;

  pcb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Class filter: all-ones include mask passes every class not excluded; exclude only covers 0..63
  always_comb begin
    logic low_class;
    low_class = (item.point_class[CLASS_W-1:6] == '0);
    class_ok  = (&cfg.include_mask) ||
                (low_class && cfg.include_mask[item.point_class[5:0]]);
    if (low_class && cfg.exclude_mask[item.point_class[5:0]]) begin
      class_ok = 1'b0;
    end
  end

  assign range_ok = ($signed(item.point_x) >= $signed(cfg.origin_x)) &&
                    ($signed(item.point_x) <= $signed(cfg.limit_x)) &&
                    ($signed(item.point_y) >= $signed(cfg.origin_y)) &&
                    ($signed(item.point_y) <= $signed(cfg.limit_y));

  assign div_start = ((state == S_CHECK) && item.command == CMD_BIN && class_ok && range_ok)
                     || ((state == S_DIVX) && div_done);

  // Keep the larger height; a cell without data takes the new point outright
  assign h_new = (!m_rd[0] || ($signed(item.point_z) > h_rd)) ? item.point_z : h_rd;

  assign h_we    = (state == S_UPD) && (item.command == CMD_BIN);
  assign m_we    = (state == S_CLEAR) || h_we;
  assign m_waddr = (state == S_CLEAR) ? clr_cnt : idx[IDXW-1:0];
  assign m_wdata = (state == S_CLEAR) ? 1'b0 : 1'b1;

  pcb_ram #(
    .WIDTH (COORD_W),
    .DEPTH (GRID_CELLS)
  ) u_height (
    .clk     (clk),
    .wr_en   (h_we),
    .wr_addr (idx[IDXW-1:0]),
    .wr_data (h_new),
    .rd_addr (idx[IDXW-1:0]),
    .rd_data (h_rd)
  );

  pcb_ram #(
    .WIDTH (1),
    .DEPTH (GRID_CELLS)
  ) u_marks (
    .clk     (clk),
    .wr_en   (m_we),
    .wr_addr (m_waddr),
    .wr_data (m_wdata),
    .rd_addr (idx[IDXW-1:0]),
    .rd_data (m_rd)
  );

  assign req_ready = (state == S_IDLE) && !res_valid;
  assign out_free  = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && out_free) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == IDXW'(GRID_CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid && req_ready) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          priority if (item.command == CMD_READ) begin
            if (32'(item.read_index) >= 32'(GRID_CELLS)) begin
              res_valid <= 1'b1;
              state     <= S_IDLE;
            end else begin
              state <= S_IDX;
            end
          end else if (!class_ok || !range_ok) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            state <= S_DIVX;
          end
        end
        S_DIVX: if (div_done) state <= S_DIVY;
        S_DIVY: if (div_done) state <= S_MUL;
        S_MUL:  state <= S_ADD;
        S_ADD:  state <= S_IDX;
        S_IDX: begin
          if (idx >= SUM_W'(GRID_CELLS)) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            state <= S_LOOK;
          end
        end
        S_LOOK: state <= S_UPD;
        S_UPD: begin
          res_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= req;
    end
    unique case (state)
      S_CHECK: begin
        idx               <= SUM_W'(item.read_index);
        res.cell_height   <= '0;
        res.cell_has_data <= 1'b0;
        priority if (item.command == CMD_READ) begin
          res.status     <= STATUS_BEYOND;
          res.cell_index <= item.read_index;
        end else if (!class_ok) begin
          res.status     <= STATUS_REJECTED;
          res.cell_index <= '0;
        end else if (!range_ok) begin
          res.status     <= STATUS_OUTSIDE;
          res.cell_index <= '0;
        end else begin
          res.status     <= STATUS_BINNED;
          res.cell_index <= '0;
        end
      end
      S_DIVX: if (div_done) rx <= div_quot;
      S_DIVY: if (div_done) ry <= div_quot;
      S_MUL:  prod <= PROD_W'(ry) * PROD_W'(cfg.grid_width);
      S_ADD:  idx  <= SUM_W'(prod) + SUM_W'(rx);
      S_IDX: begin
        res.status        <= STATUS_BEYOND;
        res.cell_index    <= idx[RIDX_W-1:0];
        res.cell_height   <= '0;
        res.cell_has_data <= 1'b0;
      end
      S_UPD: begin
        res.cell_index <= idx[RIDX_W-1:0];
        if (item.command == CMD_READ) begin
          res.status        <= STATUS_READ;
          res.cell_height   <= m_rd[0] ? h_rd : '0;
          res.cell_has_data <= m_rd[0];
        end else begin
          res.status        <= STATUS_BINNED;
          res.cell_height   <= h_new;
          res.cell_has_data <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register: load a finished result, hold it while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      rsp <= res;
    end
  end

endmodule

// ===== hdl/pcb_checker.sv =====
// Port-level checker for the binner top level, with its bind.
module pcb_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input pcb_pkg::rsp_t rsp,
  input logic          rsp_valid,
  input logic          rsp_ready
);
  import pcb_pkg::*;

  // Stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // One item at a time: no new transfer right after one is taken
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second item accepted while busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == STATUS_BINNED) || (rsp.status == STATUS_REJECTED) ||
                  (rsp.status == STATUS_OUTSIDE) || (rsp.status == STATUS_BEYOND) ||
                  (rsp.status == STATUS_READ))
    else $error("undefined status code");

  a_filtered_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && ((rsp.status == STATUS_REJECTED) || (rsp.status == STATUS_OUTSIDE))
      |-> (rsp.cell_index == '0) && (rsp.cell_height == '0) && !rsp.cell_has_data)
    else $error("filtered point reported cell data");

  a_no_stale_height: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.cell_has_data |-> rsp.cell_height == '0)
    else $error("height reported for a cell without data");

endmodule

bind point_cloud_max_height_binner_top pcb_checker u_pcb_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp       (rsp),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready)
);

// ===== sim/binner_checker.sv =====
// Cell result predictor and checker for the point cloud max-height binner.
module binner_checker #(
  parameter int unsigned GRID_CELLS = pcb_pkg::GRID_CELLS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic                        req_ready,
  input  pcb_pkg::req_t               req,
  input  logic                        rsp_valid,
  input  logic                        rsp_ready,
  input  pcb_pkg::rsp_t               rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [pcb_pkg::PADDR_W-1:0] paddr,
  input  logic [pcb_pkg::PDATA_W-1:0] pwdata,
  output int                          pending,
  output int                          mismatches
);
  import pcb_pkg::*;

  cfg_t               grid_cfg;
  logic [COORD_W-1:0] max_height   [GRID_CELLS];
  bit                 has_data     [GRID_CELLS];
  int unsigned        filled_cells [GRID_CELLS];
  int                 filled_count;
  rsp_t               expected_cells [$];

  task automatic write_register(input logic [REG_SEL_W-1:0] sel,
                                input logic [PDATA_W-1:0] value);
    case (sel)
      REG_ORIGIN_X:     grid_cfg.origin_x     = value[COORD_W-1:0];
      REG_ORIGIN_Y:     grid_cfg.origin_y     = value[COORD_W-1:0];
      REG_LIMIT_X:      grid_cfg.limit_x      = value[COORD_W-1:0];
      REG_LIMIT_Y:      grid_cfg.limit_y      = value[COORD_W-1:0];
      REG_CELL_SIZE:    grid_cfg.cell_size    = value[SIZE_W-1:0];
      REG_GRID_WIDTH:   grid_cfg.grid_width   = value[WIDTH_W-1:0];
      REG_INCLUDE_MASK: grid_cfg.include_mask = value[MASK_W-1:0];
      REG_EXCLUDE_MASK: grid_cfg.exclude_mask = value[MASK_W-1:0];
      default: ;
    endcase
  endtask

  // Work out the cell result of one command and update the cell stores.
  function automatic rsp_t predict_cell(input req_t item);
    rsp_t               res;
    logic               keep;
    logic [COORD_W-1:0] dx, dy, divisor, rx, ry;
    logic [63:0]        idx;
    int unsigned        slot;
    res = '0;
    if (item.command == CMD_READ) begin
      res.cell_index = item.read_index;
      if (item.read_index >= GRID_CELLS) begin
        res.status = STATUS_BEYOND;
      end else begin
        res.status = STATUS_READ;
        slot = 32'(item.read_index);
        res.cell_has_data = has_data[slot];
        if (has_data[slot]) res.cell_height = max_height[slot];
      end
      return res;
    end
    keep = (grid_cfg.include_mask == '1) ||
           (item.point_class < 64 && grid_cfg.include_mask[item.point_class[5:0]]);
    // Exclusion only covers the low 64 classes.
    if (item.point_class < 64 && grid_cfg.exclude_mask[item.point_class[5:0]]) keep = 1'b0;
    if (!keep) begin
      res.status = STATUS_REJECTED;
      return res;
    end
    if ($signed(item.point_x) < $signed(grid_cfg.origin_x) ||
        $signed(item.point_x) > $signed(grid_cfg.limit_x) ||
        $signed(item.point_y) < $signed(grid_cfg.origin_y) ||
        $signed(item.point_y) > $signed(grid_cfg.limit_y)) begin
      res.status = STATUS_OUTSIDE;
      return res;
    end
    dx = item.point_x - grid_cfg.origin_x;
    dy = item.point_y - grid_cfg.origin_y;
    divisor = (grid_cfg.cell_size == '0) ? 32'd1 : {12'd0, grid_cfg.cell_size};
    rx = dx / divisor;
    ry = dy / divisor;
    idx = {32'd0, ry} * {47'd0, grid_cfg.grid_width} + {32'd0, rx};
    res.cell_index = idx[RIDX_W-1:0];
    if (idx >= GRID_CELLS) begin
      res.status = STATUS_BEYOND;
      return res;
    end
    slot = idx[31:0];
    if (!has_data[slot]) begin
      max_height[slot] = item.point_z;
      filled_cells[filled_count] = slot;
      filled_count++;
    end else if ($signed(item.point_z) > $signed(max_height[slot])) begin
      max_height[slot] = item.point_z;
    end
    has_data[slot] = 1'b1;
    res.status = STATUS_BINNED;
    res.cell_height = max_height[slot];
    res.cell_has_data = 1'b1;
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      grid_cfg.origin_x     = '0;
      grid_cfg.origin_y     = '0;
      grid_cfg.limit_x      = 32'd255;
      grid_cfg.limit_y      = 32'd255;
      grid_cfg.cell_size    = 20'd1;
      grid_cfg.grid_width   = 17'd256;
      grid_cfg.include_mask = '1;
      grid_cfg.exclude_mask = '0;
      foreach (has_data[i]) has_data[i] = 1'b0;
      filled_count = 0;
      expected_cells.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready) write_register(paddr[PADDR_W-1:3], pwdata);
      if (rsp_valid && rsp_ready) begin
        if (expected_cells.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected cell result: status %0d cell %0d height %0d data %0d",
                     rsp.status, rsp.cell_index, $signed(rsp.cell_height), rsp.cell_has_data);
        end else begin
          want = expected_cells.pop_front();
          if (rsp.status !== want.status || rsp.cell_index !== want.cell_index ||
              rsp.cell_height !== want.cell_height ||
              rsp.cell_has_data !== want.cell_has_data) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"cell result mismatch: want status %0d cell %0d height %0d data %0d,",
                        " got status %0d cell %0d height %0d data %0d"},
                       want.status, want.cell_index, $signed(want.cell_height),
                       want.cell_has_data, rsp.status, rsp.cell_index,
                       $signed(rsp.cell_height), rsp.cell_has_data);
          end
        end
      end
      if (req_valid && req_ready)
        expected_cells.insert(expected_cells.size(), predict_cell(req));
    end
    pending = expected_cells.size();
  end

endmodule

// ===== sim/testbench.sv =====
// Stimulus, configuration phases and verdict for the point cloud max-height binner.
module testbench;
  import pcb_pkg::*;

  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          SETTLE_TICKS = 60;
  localparam logic [31:0] COORD_MIN    = 32'h8000_0000;
  localparam logic [31:0] COORD_MAX    = 32'h7FFF_FFFF;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  req_t               req       = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  rsp_t               rsp;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [PDATA_W-1:0] pwdata    = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 pending;
  int                 mismatches;

  // Window currently programmed, used to aim points at the covered range.
  int win_ox = 0;
  int win_oy = 0;
  int win_lx = 255;
  int win_ly = 255;
  bit steady_sender = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  point_cloud_max_height_binner_top DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  binner_checker cell_chk (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .pending(pending), .mismatches(mismatches)
  );

  function automatic int pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Mostly inside the window, with edges, just-outside values and noise.
  function automatic logic [31:0] pick_coord(input int lo, input int hi);
    longint          span;
    longint unsigned offset;
    int unsigned     sel;
    span = longint'(hi) - longint'(lo);
    sel = $urandom_range(0, 99);
    offset = {$urandom, $urandom};
    if (span < 0 || sel < 12) return $urandom;
    if (sel < 18) return lo;
    if (sel < 24) return hi;
    if (sel < 27) return lo - 1;
    if (sel < 30) return hi + 1;
    offset = offset % unsigned'(span + 1);
    return 32'(longint'(lo) + longint'(offset));
  endfunction

  function automatic req_t random_item();
    req_t        item;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    item.command     = CMD_BIN;
    item.point_x     = pick_coord(win_ox, win_lx);
    item.point_y     = pick_coord(win_oy, win_ly);
    item.point_z     = ($urandom_range(0, 99) < 40) ? $urandom
                                                    : int'($urandom_range(0, 2000)) - 1000;
    item.point_class = ($urandom_range(0, 99) < 55) ? CLASS_W'($urandom_range(0, 63))
                                                    : CLASS_W'($urandom_range(0, 255));
    item.read_index  = RIDX_W'($urandom);
    // Read back only cells that already hold a height.
    if (sel < 20 && cell_chk.filled_count > 0) begin
      item.command    = CMD_READ;
      item.read_index = RIDX_W'(cell_chk.filled_cells[$urandom_range(0,
                                                      cell_chk.filled_count - 1)]);
    end
    return item;
  endfunction

  task automatic send_item(input req_t item);
    int gap;
    gap = steady_sender ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  task automatic bin_point(input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z, input logic [7:0] cls);
    req_t item;
    item.command     = CMD_BIN;
    item.point_x     = x;
    item.point_y     = y;
    item.point_z     = z;
    item.point_class = cls;
    item.read_index  = RIDX_W'($urandom);
    send_item(item);
  endtask

  task automatic read_cell(input logic [RIDX_W-1:0] index);
    req_t item;
    item.command     = CMD_READ;
    item.point_x     = $urandom;
    item.point_y     = $urandom;
    item.point_z     = $urandom;
    item.point_class = CLASS_W'($urandom);
    item.read_index  = index;
    send_item(item);
  endtask

  // Hold off new commands until every outstanding cell result has come back.
  task automatic drain();
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_SEL_W-1:0] sel, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_window(input int ox, input int oy, input int lx, input int ly);
    write_reg(REG_ORIGIN_X, {32'd0, ox});
    write_reg(REG_ORIGIN_Y, {32'd0, oy});
    write_reg(REG_LIMIT_X, {32'd0, lx});
    write_reg(REG_LIMIT_Y, {32'd0, ly});
    win_ox = ox;
    win_oy = oy;
    win_lx = lx;
    win_ly = ly;
  endtask

  task automatic set_grid(input logic [SIZE_W-1:0] size, input logic [WIDTH_W-1:0] width);
    write_reg(REG_CELL_SIZE, {44'd0, size});
    write_reg(REG_GRID_WIDTH, {47'd0, width});
  endtask

  task automatic set_masks(input logic [MASK_W-1:0] incl, input logic [MASK_W-1:0] excl);
    write_reg(REG_INCLUDE_MASK, incl);
    write_reg(REG_EXCLUDE_MASK, excl);
  endtask

  function automatic logic [MASK_W-1:0] sparse_mask();
    return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
  endfunction

  task automatic run_phase(input int count, input bit steady);
    steady_sender = steady;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2 && count >= 250) drain();
      send_item(random_item());
    end
    steady_sender = 1'b0;
  endtask

  // Response side: bursts of ready with short and occasional long stalls.
  initial begin
    int run_len;
    int gap;
    @(negedge clk);
    forever begin
      run_len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(50, 300);
      rsp_ready <= 1'b1;
      repeat (run_len) @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset configuration: 256 x 256 grid of unit cells.
    bin_point(0, 0, COORD_MIN, 0);
    bin_point(0, 0, COORD_MAX, 255);
    bin_point(0, 0, 7, 64);
    bin_point(255, 255, 32'hFFFF_FFFF, 63);
    read_cell(0);
    read_cell(16'hFFFF);
    bin_point(256, 0, 1, 1);
    bin_point(32'hFFFF_FFFF, 0, 1, 1);
    bin_point(0, 256, 1, 1);
    bin_point(0, 32'hFFFF_FFFF, 1, 1);
    bin_point(COORD_MIN, COORD_MAX, 1, 1);
    bin_point(255, 0, 100, 2);
    read_cell(255);

    // Class filtering: include list versus all-ones, exclusion of low classes only.
    drain();
    set_masks(64'h1, 64'h0);
    bin_point(1, 0, 5, 0);
    bin_point(1, 0, 5, 1);
    bin_point(1, 0, 5, 64);
    drain();
    set_masks('1, 64'h8000_0000_0000_0001);
    bin_point(2, 0, 9, 0);
    bin_point(2, 0, 9, 63);
    bin_point(2, 0, 9, 64);
    bin_point(2, 0, 9, 200);

    // Index past the store, zero cell size and zero grid width, inverted range.
    drain();
    set_grid(1, 17'd65536);
    bin_point(0, 1, 3, 5);
    bin_point(255, 255, 3, 5);
    drain();
    set_grid(0, 0);
    bin_point(77, 200, 42, 5);
    drain();
    set_window(10, 0, 5, 255);
    bin_point(7, 5, 1, 5);
    read_cell(77);

    drain();
    set_window(-500, -500, 499, 499);
    set_grid(37, 28);
    set_masks('1, '0);
    run_phase(300, 1'b0);

    drain();
    set_window(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    set_grid(20'hFFFFF, 16);
    set_masks('1, sparse_mask());
    run_phase(200, 1'b0);

    drain();
    set_window(1000, COORD_MIN, 1000, COORD_MIN + 4095);
    set_grid(0, 17'h1FFFF);
    set_masks({$urandom, $urandom}, '0);
    run_phase(150, 1'b1);

    drain();
    set_window(10, -20, 5, 40);
    set_grid(4, 20);
    set_masks('1, '0);
    run_phase(100, 1'b1);

    drain();
    set_window(0, 0, 199999, 50);
    set_grid(3, 0);
    set_masks('1, sparse_mask());
    run_phase(200, 1'b0);

    drain();
    set_window(-100, -100, 100, 100);
    set_grid(1, 1);
    set_masks(64'hFFFF_FFFF_FFFF_FFFE, '0);
    run_phase(250, 1'b0);

    drain();
    set_window(0, 0, 255, 255);
    set_grid(1, 256);
    set_masks('1, '0);
    run_phase(325, 1'b0);

    drain();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pcb_pkg.sv
hdl/pcb_ram.sv
hdl/pcb_div.sv
hdl/pcb_regs.sv
hdl/point_cloud_max_height_binner_top.sv
hdl/pcb_checker.sv
sim/binner_checker.sv
sim/testbench.sv
